// ----- rtl/lbm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the label boundary marker.
// Used by every module of the block but lbm_fifo; depends on nothing.
package lbm_pkg;

	// Field widths
	localparam int LABEL_BITS    = 16;
	localparam int CH_BITS       = 8;
	localparam int ROW_BITS      = 12;
	localparam int OUT_COL_BITS  = 11;
	localparam int FW_BITS       = 12;
	localparam int FH_BITS       = 13;
	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS = 13;

	// Frame limits and reset geometry
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int MAX_HEIGHT    = 4096;
	localparam int RESET_WIDTH   = 640;
	localparam int RESET_HEIGHT  = 480;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

	// Queues: at most RES_MAX results per pixel; OUTQ_DEPTH is a power of two
	localparam int MIDQ_DEPTH    = 4;
	localparam int RES_MAX       = 3;
	localparam int RES_CNT_BITS  = $clog2(RES_MAX + 1);
	localparam int OUTQ_DEPTH    = 8;
	localparam int OUTQ_LVL_BITS = $clog2(OUTQ_DEPTH + 1);

	// Overlay colour of a boundary pixel
	localparam logic [CH_BITS-1:0] MARK_CH0 = CH_BITS'(0);
	localparam logic [CH_BITS-1:0] MARK_CH1 = CH_BITS'(0);
	localparam logic [CH_BITS-1:0] MARK_CH2 = CH_BITS'(255);

	typedef struct packed {
		logic [LABEL_BITS-1:0] seg_label;
		logic [CH_BITS-1:0]    in_ch0;
		logic [CH_BITS-1:0]    in_ch1;
		logic [CH_BITS-1:0]    in_ch2;
	} pix_in_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]     out_row;
		logic [OUT_COL_BITS-1:0] out_col;
		logic [CH_BITS-1:0]      out_ch0;
		logic [CH_BITS-1:0]      out_ch1;
		logic [CH_BITS-1:0]      out_ch2;
		logic                    is_boundary;
		logic                    last_of_run;
	} pix_out_t;

	// Position class of an accepted pixel, worked out by the front end
	typedef struct packed {
		logic prev_row;   // row >= 1: the row above is due for output
		logic top_ok;     // row >= 2: the row above has a row above it
		logic left_ok;    // col >= 1
		logic left2_ok;   // col >= 2
		logic right_ok;   // col + 1 < width
		logic last_row;   // row + 1 == height
		logic last_col;   // col + 1 == width
	} lbm_flags_t;

endpackage

// ----- rtl/label_boundary_marker.sv -----
`timescale 1ns / 1ps
// Top level of the segment boundary overlay: front end, pixel queue, back end, result queue.
// Depends on lbm_pkg, lbm_front, lbm_fifo, lbm_back and lbm_outq.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  config   | cfg_valid / cfg_ready | cfg_index (register), cfg_data
//  pixels   | push / full           | pixel: seg_label, in_ch0..in_ch2
//  results  | pop / empty           | result: row, col, channels, flags
//
// One pixel per clock outside the last row while the result queue has room; each pixel's
// results go through the pixel queue and stage 1 of the back end into the result queue. In
// the last row of a frame of two or more rows each pixel after the first of the row gives two
// results (three for the final one), so the output port, at one transfer a clock, sets the rate.
// Reset loads 640 x 480 and restarts at row 0, column 0; the line stores need no clearing.
// A stalled output fills the result queue as far as the room kept for results in flight
// allows, then the four-entry pixel queue, then raises full.
module label_boundary_marker #(
	parameter int MAX_WIDTH = lbm_pkg::DEF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lbm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [lbm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               push,
	output logic                               full,
	input  lbm_pkg::pix_in_t                   pixel,
	input  logic                               pop,
	output logic                               empty,
	output lbm_pkg::pix_out_t                  result
);
	import lbm_pkg::*;

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int MIDQ_W = $bits(lbm_flags_t) + ROW_BITS + AW + $bits(pix_in_t);

	logic                                midq_push;
	logic                                midq_full;
	logic                                midq_empty;
	logic                                midq_pop;
	logic [MIDQ_W-1:0]                   midq_wr;
	logic [MIDQ_W-1:0]                   midq_rd;
	lbm_flags_t                          f_flags;
	logic [ROW_BITS-1:0]                 f_row;
	logic [AW-1:0]                       f_col;
	pix_in_t                             f_pix;
	lbm_flags_t                          h_flags;
	logic [ROW_BITS-1:0]                 h_row;
	logic [AW-1:0]                       h_col;
	pix_in_t                             h_pix;
	logic [OUTQ_LVL_BITS-1:0]            out_level;
	logic [RES_CNT_BITS-1:0]             res_count;
	pix_out_t [RES_MAX-1:0]              res_data;

	lbm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.pixel      (pixel),
		.midq_full  (midq_full),
		.midq_push  (midq_push),
		.item_flags (f_flags),
		.item_row   (f_row),
		.item_col   (f_col),
		.item_pix   (f_pix)
	);

	// Carry classified pixels from front to back
	assign midq_wr = {f_flags, f_row, f_col, f_pix};
	assign {h_flags, h_row, h_col, h_pix} = midq_rd;

	lbm_fifo #(.WIDTH(MIDQ_W), .DEPTH(MIDQ_DEPTH)) u_midq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (midq_push),
		.wr_data (midq_wr),
		.full    (midq_full),
		.rd_en   (midq_pop),
		.rd_data (midq_rd),
		.empty   (midq_empty)
	);

	lbm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!midq_empty),
		.head_flags (h_flags),
		.head_row   (h_row),
		.head_col   (h_col),
		.head_pix   (h_pix),
		.head_pop   (midq_pop),
		.out_level  (out_level),
		.res_count  (res_count),
		.res_data   (res_data)
	);

	lbm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (res_count),
		.push_data (res_data),
		.level     (out_level),
		.pop       (pop),
		.empty     (empty),
		.head      (result)
	);

endmodule

// ----- rtl/lbm_fifo.sv -----
`timescale 1ns / 1ps
// Small first-word-fall-through queue of flip-flops, one write and one read a cycle.
// Generic; no package dependency.
module lbm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_fire;
	logic             rd_fire;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_fire = wr_en && !full;
	assign rd_fire = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store entry
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(wr_fire) - CW'(rd_fire);
		end
	end

endmodule

// ----- rtl/lbm_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, raster position counters and pixel classification.
// Depends on lbm_pkg.
module lbm_front #(
	parameter int MAX_WIDTH = lbm_pkg::DEF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lbm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [lbm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               push,
	output logic                               full,
	input  lbm_pkg::pix_in_t                   pixel,
	input  logic                               midq_full,
	output logic                               midq_push,
	output lbm_pkg::lbm_flags_t                item_flags,
	output logic [lbm_pkg::ROW_BITS-1:0]       item_row,
	output logic [$clog2(MAX_WIDTH)-1:0]       item_col,
	output lbm_pkg::pix_in_t                   item_pix
);
	import lbm_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [FW_BITS-1:0]  fw_q;
	logic [FH_BITS-1:0]  fh_q;
	logic [ROW_BITS-1:0] row_q;
	logic [AW-1:0]       col_q;
	logic [AW:0]         eff_w;
	logic [FH_BITS-1:0]  eff_h;
	logic [AW:0]         col_nx;
	logic [FH_BITS-1:0]  row_nx;
	logic                cfg_fire;
	logic                accept;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign full      = midq_full;
	assign accept    = push && !midq_full;
	assign midq_push = accept;

	// Clamp the programmed geometry
	always_comb begin
		if (fw_q == '0) begin
			eff_w = (AW+1)'(1);
		end else if ({20'd0, fw_q} > 32'(MAX_WIDTH)) begin
			eff_w = (AW+1)'(MAX_WIDTH);
		end else begin
			eff_w = (AW+1)'(fw_q);
		end
		if (fh_q == '0) begin
			eff_h = FH_BITS'(1);
		end else if (fh_q > FH_BITS'(MAX_HEIGHT)) begin
			eff_h = FH_BITS'(MAX_HEIGHT);
		end else begin
			eff_h = fh_q;
		end
	end

	assign col_nx = {1'b0, col_q} + (AW+1)'(1);
	assign row_nx = {1'b0, row_q} + FH_BITS'(1);

	// Classify the pixel at the current position
	always_comb begin
		item_flags.prev_row = (row_q != '0);
		item_flags.top_ok   = (row_q >= ROW_BITS'(2));
		item_flags.left_ok  = (col_q != '0);
		item_flags.left2_ok = ({1'b0, col_q} >= (AW+1)'(2));
		item_flags.right_ok = (col_nx < eff_w);
		item_flags.last_row = (row_nx == eff_h);
		item_flags.last_col = (col_nx == eff_w);
	end

	assign item_row = row_q;
	assign item_col = col_q;
	assign item_pix = pixel;

	// Hold geometry; advance position per transfer; restart the frame on a width or height write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FW_BITS'(RESET_WIDTH);
			fh_q  <= FH_BITS'(RESET_HEIGHT);
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					fw_q  <= cfg_data[FW_BITS-1:0];
					row_q <= '0;
					col_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					fh_q  <= cfg_data;
					row_q <= '0;
					col_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (item_flags.last_col) begin
				col_q <= '0;
				row_q <= item_flags.last_row ? '0 : row_nx[ROW_BITS-1:0];
			end else begin
				col_q <= col_nx[AW-1:0];
			end
		end
	end

endmodule

// ----- rtl/lbm_back.sv -----
`timescale 1ns / 1ps
// Back end: line stores, neighbour lookup and boundary marking, up to three results a pixel.
// Depends on lbm_pkg; feeds lbm_outq.
module lbm_back #(
	parameter int MAX_WIDTH = lbm_pkg::DEF_MAX_WIDTH
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             head_valid,
	input  lbm_pkg::lbm_flags_t                              head_flags,
	input  logic [lbm_pkg::ROW_BITS-1:0]                     head_row,
	input  logic [$clog2(MAX_WIDTH)-1:0]                     head_col,
	input  lbm_pkg::pix_in_t                                 head_pix,
	output logic                                             head_pop,
	input  logic [lbm_pkg::OUTQ_LVL_BITS-1:0]                out_level,
	output logic [lbm_pkg::RES_CNT_BITS-1:0]                 res_count,
	output lbm_pkg::pix_out_t [lbm_pkg::RES_MAX-1:0]         res_data
);
	import lbm_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CLW = 3 * CH_BITS;
	localparam logic [OUTQ_LVL_BITS-1:0] ROOM_ONE = OUTQ_LVL_BITS'(OUTQ_DEPTH - RES_MAX);
	localparam logic [OUTQ_LVL_BITS-1:0] ROOM_TWO = OUTQ_LVL_BITS'(OUTQ_DEPTH - 2 * RES_MAX);

	// Line stores: pending row (labels, colours) and the row above it (labels)
	logic [LABEL_BITS-1:0] pend_lab_mem [MAX_WIDTH];
	logic [CLW-1:0]        pend_col_mem [MAX_WIDTH];
	logic [LABEL_BITS-1:0] above_mem    [MAX_WIDTH];

	// Stage 1
	logic                  s1_valid_q;
	logic                  byp_s1;
	lbm_flags_t            flags_s1;
	logic [ROW_BITS-1:0]   row_s1;
	logic [AW-1:0]         col_s1;
	logic [LABEL_BITS-1:0] lab_s1;
	logic [CLW-1:0]        colour_s1;
	logic [LABEL_BITS-1:0] pc_s1;
	logic [LABEL_BITS-1:0] pn_s1;
	logic [CLW-1:0]        pcol_s1;
	logic [LABEL_BITS-1:0] a_s1;

	// Previous pixel of the stream
	logic [LABEL_BITS-1:0] prev_p_q;
	logic [LABEL_BITS-1:0] prev_lab_q;
	logic [LABEL_BITS-1:0] prev2_lab_q;
	logic [CLW-1:0]        prev_colour_q;

	logic                  credit;
	logic [AW-1:0]         nxt_addr;
	logic [LABEL_BITS-1:0] a_eff;
	logic                  va;
	logic                  vb;
	logic                  vc;
	pix_out_t              res_a;
	pix_out_t              res_b;
	pix_out_t              res_c;

	function automatic pix_out_t mark_pixel(
		input logic [ROW_BITS-1:0]   row,
		input logic [AW-1:0]         col,
		input logic [LABEL_BITS-1:0] lab,
		input logic [LABEL_BITS-1:0] top,
		input logic [LABEL_BITS-1:0] bot,
		input logic [LABEL_BITS-1:0] lft,
		input logic [LABEL_BITS-1:0] rgt,
		input logic [CLW-1:0]        colour,
		input logic                  last
	);
		pix_out_t o;
		logic     hit;
		hit           = (lab != top) || (lab != bot) || (lab != lft) || (lab != rgt);
		o.out_row     = row;
		o.out_col     = OUT_COL_BITS'(col);
		o.out_ch0     = hit ? MARK_CH0 : colour[CH_BITS-1:0];
		o.out_ch1     = hit ? MARK_CH1 : colour[2*CH_BITS-1:CH_BITS];
		o.out_ch2     = hit ? MARK_CH2 : colour[3*CH_BITS-1:2*CH_BITS];
		o.is_boundary = hit;
		o.last_of_run = last;
		return o;
	endfunction

	// Take a pixel only when the result queue can absorb everything in flight
	assign credit   = s1_valid_q ? (out_level <= ROOM_TWO) : (out_level <= ROOM_ONE);
	assign head_pop = head_valid && credit;
	assign nxt_addr = head_flags.right_ok ? head_col + AW'(1) : head_col;

	// Read neighbours, store the new pixel, load stage 1
	always_ff @(posedge clk) begin
		if (head_pop) begin
			pend_lab_mem[head_col] <= head_pix.seg_label;
			pend_col_mem[head_col] <= {head_pix.in_ch2, head_pix.in_ch1, head_pix.in_ch0};
			pc_s1     <= pend_lab_mem[head_col];
			pn_s1     <= pend_lab_mem[nxt_addr];
			pcol_s1   <= pend_col_mem[head_col];
			a_s1      <= above_mem[head_col];
			flags_s1  <= head_flags;
			row_s1    <= head_row;
			col_s1    <= head_col;
			lab_s1    <= head_pix.seg_label;
			colour_s1 <= {head_pix.in_ch2, head_pix.in_ch1, head_pix.in_ch0};
		end
		if (s1_valid_q) begin
			above_mem[col_s1] <= pc_s1;
			prev_p_q          <= pc_s1;
			prev_lab_q        <= lab_s1;
			prev2_lab_q       <= prev_lab_q;
			prev_colour_q     <= colour_s1;
		end
	end

	// Track stage occupancy; flag a read of the above entry being written this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_s1     <= 1'b0;
		end else begin
			s1_valid_q <= head_pop;
			byp_s1     <= head_pop && s1_valid_q && (col_s1 == head_col);
		end
	end

	assign a_eff = byp_s1 ? prev_p_q : a_s1;
	assign va    = flags_s1.prev_row;
	assign vb    = flags_s1.last_row && flags_s1.left_ok;
	assign vc    = flags_s1.last_row && flags_s1.last_col;

	// Mark the pixel of the row above, then the last-row pixels
	always_comb begin
		res_a = mark_pixel(row_s1 - ROW_BITS'(1), col_s1, pc_s1,
			flags_s1.top_ok ? a_eff : pc_s1,
			lab_s1,
			flags_s1.left_ok ? prev_p_q : pc_s1,
			flags_s1.right_ok ? pn_s1 : pc_s1,
			pcol_s1, !(vb || vc));
		res_b = mark_pixel(row_s1, col_s1 - AW'(1), prev_lab_q,
			flags_s1.prev_row ? prev_p_q : prev_lab_q,
			prev_lab_q,
			flags_s1.left2_ok ? prev2_lab_q : prev_lab_q,
			lab_s1,
			prev_colour_q, !vc);
		res_c = mark_pixel(row_s1, col_s1, lab_s1,
			flags_s1.prev_row ? pc_s1 : lab_s1,
			lab_s1,
			flags_s1.left_ok ? prev_lab_q : lab_s1,
			lab_s1,
			colour_s1, 1'b1);
	end

	// Pack valid results to the front in order
	always_comb begin
		res_count   = s1_valid_q ?
			RES_CNT_BITS'(va) + RES_CNT_BITS'(vb) + RES_CNT_BITS'(vc) : '0;
		res_data[0] = va ? res_a : (vb ? res_b : res_c);
		res_data[1] = (va && vb) ? res_b : res_c;
		res_data[2] = res_c;
	end

	a_byp_one_col: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> (s1_valid_q && col_s1 == '0))
		else $error("above-store bypass outside a one-column frame");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> ({28'd0, out_level} + {30'd0, res_count} <= 32'(OUTQ_DEPTH)))
		else $error("results exceed reserved queue room");

	a_one_res: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !flags_s1.last_row) |-> (res_count <= RES_CNT_BITS'(1)))
		else $error("more than one result outside the last row");

endmodule

// ----- rtl/lbm_outq.sv -----
`timescale 1ns / 1ps
// Result queue: takes up to three results a cycle, hands out one a cycle.
// Depends on lbm_pkg.
module lbm_outq (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [lbm_pkg::RES_CNT_BITS-1:0]             push_n,
	input  lbm_pkg::pix_out_t [lbm_pkg::RES_MAX-1:0]     push_data,
	output logic [lbm_pkg::OUTQ_LVL_BITS-1:0]            level,
	input  logic                                         pop,
	output logic                                         empty,
	output lbm_pkg::pix_out_t                            head
);
	import lbm_pkg::*;

	localparam int PW = $clog2(OUTQ_DEPTH);

	pix_out_t                 mem_q [OUTQ_DEPTH];
	logic [PW-1:0]            wr_ptr_q;
	logic [PW-1:0]            rd_ptr_q;
	logic [OUTQ_LVL_BITS-1:0] level_q;
	logic                     pop_fire;

	assign empty    = (level_q == '0);
	assign level    = level_q;
	assign pop_fire = pop && !empty;
	assign head     = mem_q[rd_ptr_q];

	// Write results at consecutive slots
	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (RES_CNT_BITS'(i) < push_n) begin
				mem_q[wr_ptr_q + PW'(i)] <= push_data[i];
			end
		end
	end

	// Advance pointers; pointers wrap on the power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			rd_ptr_q <= rd_ptr_q + PW'(pop_fire);
			level_q  <= level_q + OUTQ_LVL_BITS'(push_n) - OUTQ_LVL_BITS'(pop_fire);
		end
	end

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= OUTQ_LVL_BITS'(OUTQ_DEPTH))
		else $error("result queue level beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != '0) |-> ({28'd0, level_q} + {30'd0, push_n} <= 32'(OUTQ_DEPTH)))
		else $error("result queue overflow");

	a_pop_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && push_n == '0) |=> (level_q == $past(level_q) - OUTQ_LVL_BITS'(1)))
		else $error("result queue level did not drop after a transfer");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for label_boundary_marker: a directed table, the start of the widest and tallest
// frames, a stalled-receiver run and random frames, checked by typed or line-buffer predictions.
// Depends on lbm_pkg and the label_boundary_marker RTL.
module testbench;
	import lbm_pkg::*;

	localparam int MAX_W        = DEF_MAX_WIDTH;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 120;
	localparam int EDGE_ITEMS   = 24;
	localparam int RANDOM_ITEMS = 264;
	localparam int MAX_REPORTS  = 10;
	localparam int TIMEOUT_NS   = 5_000_000;

	// Index that selects no register; a write to it must leave the frame position alone
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(15);

	typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;

	// One row of the directed table: a register write or a pixel, optionally with typed results
	typedef struct packed {
		step_kind_t               kind;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] data;
		pix_in_t                  pix;
		logic                     typed;
		logic [1:0]               n_typed;
		pix_out_t [1:0]           want;
	} dir_step_t;

	localparam pix_out_t NO_RES = '0;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     push      = 1'b0;
	logic                     full;
	pix_in_t                  pixel     = '0;
	logic                     pop       = 1'b0;
	logic                     empty;
	pix_out_t                 result;

	label_boundary_marker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.pixel(pixel),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	// Shadow line buffers and frame position
	logic [LABEL_BITS-1:0] above_lab [MAX_W];
	logic [LABEL_BITS-1:0] pend_lab  [MAX_W];
	logic [3*CH_BITS-1:0]  pend_rgb  [MAX_W];
	int next_row   = 0;
	int next_col   = 0;
	int width_reg  = RESET_WIDTH;
	int height_reg = RESET_HEIGHT;

	pix_out_t expected_results [$];
	pix_out_t oldest_expected;

	int mismatches    = 0;
	int results_seen  = 0;
	int pixels_sent   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	logic [LABEL_BITS-1:0] label_base [2];
	logic [LABEL_BITS-1:0] last_label = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Build one overlay result from a pixel's label, its four neighbors and its colors
	function automatic pix_out_t overlay(input int row, input int col,
		input logic [LABEL_BITS-1:0] lab, input logic [LABEL_BITS-1:0] top,
		input logic [LABEL_BITS-1:0] bot, input logic [LABEL_BITS-1:0] lft,
		input logic [LABEL_BITS-1:0] rgt, input logic [3*CH_BITS-1:0] rgb);
		pix_out_t o;
		logic     mark;
		mark          = (lab != top) || (lab != bot) || (lab != lft) || (lab != rgt);
		o.out_row     = ROW_BITS'(row);
		o.out_col     = OUT_COL_BITS'(col);
		o.out_ch0     = mark ? MARK_CH0 : rgb[CH_BITS-1:0];
		o.out_ch1     = mark ? MARK_CH1 : rgb[2*CH_BITS-1:CH_BITS];
		o.out_ch2     = mark ? MARK_CH2 : rgb[3*CH_BITS-1:2*CH_BITS];
		o.is_boundary = mark;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	// Advance the shadow state by one pixel and return the results it releases
	function automatic int predict_pixel(input pix_in_t p, output pix_out_t [2:0] res);
		int w, h, r, c, n;
		logic [3*CH_BITS-1:0]  rgb_in;
		logic [LABEL_BITS-1:0] lab, top, lft, rgt;
		w      = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
		h      = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		r      = next_row;
		c      = next_col;
		n      = 0;
		res    = '0;
		rgb_in = {p.in_ch2, p.in_ch1, p.in_ch0};
		if (r >= h) r = 0;
		if (c >= w) c = 0;
		// release the pending pixel of this column now that its lower neighbor is known
		if (r >= 1) begin
			lab    = pend_lab[c];
			top    = (r >= 2) ? above_lab[c] : lab;
			lft    = (c > 0) ? above_lab[c-1] : lab;
			rgt    = (c + 1 < w) ? pend_lab[c+1] : lab;
			res[n] = overlay(r - 1, c, lab, top, p.seg_label, lft, rgt, pend_rgb[c]);
			n++;
			above_lab[c] = lab;
		end
		pend_lab[c] = p.seg_label;
		pend_rgb[c] = rgb_in;
		// last row has nothing below: release the left neighbor, and this pixel at row end
		if (r + 1 == h) begin
			if (c >= 1) begin
				lab    = pend_lab[c-1];
				top    = (r >= 1) ? above_lab[c-1] : lab;
				lft    = (c >= 2) ? pend_lab[c-2] : lab;
				res[n] = overlay(r, c - 1, lab, top, lab, lft, p.seg_label, pend_rgb[c-1]);
				n++;
			end
			if (c + 1 == w) begin
				top    = (r >= 1) ? above_lab[c] : p.seg_label;
				lft    = (c >= 1) ? pend_lab[c-1] : p.seg_label;
				res[n] = overlay(r, c, p.seg_label, top, p.seg_label, lft, p.seg_label, rgb_in);
				n++;
			end
		end
		if (n > 0) res[n-1].last_of_run = 1'b1;
		// step the raster position, wrapping at frame end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		next_row = r;
		next_col = c;
		return n;
	endfunction

	function automatic pix_out_t pixel_result(input int row, input int col,
		input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
		input logic b, input logic l);
		pix_out_t o;
		o.out_row     = ROW_BITS'(row);
		o.out_col     = OUT_COL_BITS'(col);
		o.out_ch0     = c0;
		o.out_ch1     = c1;
		o.out_ch2     = c2;
		o.is_boundary = b;
		o.last_of_run = l;
		return o;
	endfunction

	function automatic dir_step_t cfg_step(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		dir_step_t s;
		s      = '0;
		s.kind = STEP_CFG;
		s.idx  = idx;
		s.data = val;
		return s;
	endfunction

	function automatic dir_step_t pix_step(input logic [LABEL_BITS-1:0] lab,
		input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
		input logic typed, input int n, input pix_out_t w0, input pix_out_t w1);
		dir_step_t s;
		s         = '0;
		s.kind    = STEP_PIX;
		s.pix     = {lab, c0, c1, c2};
		s.typed   = typed;
		s.n_typed = 2'(n);
		s.want    = {w1, w0};
		return s;
	endfunction

	function automatic void new_label_bases();
		label_base[0] = LABEL_BITS'($urandom);
		label_base[1] = LABEL_BITS'($urandom);
		last_label    = label_base[0];
	endfunction

	// Labels mostly repeat the left neighbor or pick one of two regions, with some noise
	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		case ($urandom_range(9))
			0: last_label = LABEL_BITS'($urandom);
			1, 2, 3, 4: ;
			default: last_label = label_base[$urandom_range(1)];
		endcase
		p.seg_label = last_label;
		p.in_ch0    = CH_BITS'($urandom);
		p.in_ch1    = CH_BITS'($urandom);
		p.in_ch2    = CH_BITS'($urandom);
		return p;
	endfunction

	function automatic void set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 15; recv_idle_pct = 47; end
			1: begin send_idle_pct = 47; recv_idle_pct = 15; end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
		endcase
	endfunction

	// Write one register; hold valid high when another write follows directly
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val, input bit more);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (!more) cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = int'(val[FW_BITS-1:0]);
				next_row  = 0;
				next_col  = 0;
			end
			REG_FRAME_HEIGHT: begin
				height_reg = int'(val[FH_BITS-1:0]);
				next_row   = 0;
				next_col   = 0;
			end
			default: ;
		endcase
	endtask

	// Offer one pixel, with random idle cycles in front, until it transfers
	task automatic send_pixel(input pix_in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (full) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic offer_pixel(input pix_in_t p);
		pix_out_t [2:0] res;
		int             n;
		send_pixel(p);
		n = predict_pixel(p, res);
		for (int k = 0; k < n; k++) expected_results.push_back(res[k]);
	endtask

	task automatic wait_results();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Pixels in row 0 release nothing, so give them time to settle after the last result
	task automatic drain();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: check each transferred result, stall at random or for a requested hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result at %0t: row %0d col %0d", $time,
							result.out_row, result.out_col);
				end else begin
					oldest_expected = expected_results.pop_front();
					if (result !== oldest_expected) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"mismatch at %0t: want r%0d c%0d ch %h %h %h b%b l%b,",
								" got r%0d c%0d ch %h %h %h b%b l%b"}, $time,
								oldest_expected.out_row, oldest_expected.out_col,
								oldest_expected.out_ch0, oldest_expected.out_ch1,
								oldest_expected.out_ch2, oldest_expected.is_boundary,
								oldest_expected.last_of_run,
								result.out_row, result.out_col, result.out_ch0,
								result.out_ch1, result.out_ch2, result.is_boundary,
								result.last_of_run);
					end
				end
			end
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		dir_step_t      steps [$];
		pix_out_t [2:0] res;
		int             n, w, h, frames, count, phases, random_items;
		logic [CFG_DATA_BITS-1:0] wdata, hdata;
		phases       = 0;
		random_items = 0;

		// after reset the frame is 640 x 480, so row 0 releases nothing
		steps.push_back(pix_step(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, NO_RES, NO_RES));
		steps.push_back(pix_step(16'h0000, 8'h00, 8'h00, 8'h00, 1, 0, NO_RES, NO_RES));
		// zero width and height act as one: every pixel is its own frame
		steps.push_back(cfg_step(REG_FRAME_WIDTH, '0));
		steps.push_back(cfg_step(REG_FRAME_HEIGHT, '0));
		steps.push_back(pix_step(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1, 1,
			pixel_result(0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1), NO_RES));
		steps.push_back(pix_step(16'h0000, 8'h00, 8'h00, 8'h00, 1, 1,
			pixel_result(0, 0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1), NO_RES));
		// two-pixel single-row frame: differing labels mark both pixels
		steps.push_back(cfg_step(REG_FRAME_HEIGHT, 13'd1));
		steps.push_back(cfg_step(REG_FRAME_WIDTH, 13'd2));
		steps.push_back(pix_step(16'h0001, 8'h10, 8'h20, 8'h30, 1, 0, NO_RES, NO_RES));
		steps.push_back(pix_step(16'h0002, 8'h40, 8'h50, 8'h60, 1, 2,
			pixel_result(0, 0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0),
			pixel_result(0, 1, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1)));
		steps.push_back(pix_step(16'h0005, 8'hA1, 8'hB2, 8'hC3, 0, 0, NO_RES, NO_RES));
		steps.push_back(pix_step(16'h0005, 8'hD4, 8'hE5, 8'hF6, 0, 0, NO_RES, NO_RES));
		// a write to an unused index must not restart the frame
		steps.push_back(pix_step(16'h0009, 8'h01, 8'h02, 8'h03, 1, 0, NO_RES, NO_RES));
		steps.push_back(cfg_step(REG_UNUSED, 13'h1FFF));
		steps.push_back(pix_step(16'h0009, 8'h04, 8'h05, 8'h06, 1, 2,
			pixel_result(0, 0, 8'h01, 8'h02, 8'h03, 1'b0, 1'b0),
			pixel_result(0, 1, 8'h04, 8'h05, 8'h06, 1'b0, 1'b1)));
		// 3 x 3 frame with three regions
		steps.push_back(cfg_step(REG_FRAME_WIDTH, 13'd3));
		steps.push_back(cfg_step(REG_FRAME_HEIGHT, 13'd3));
		for (int i = 0; i < 9; i++)
			steps.push_back(pix_step((i >= 6) ? 16'd3 : (i % 3 == 2) ? 16'd2 : 16'd1,
				8'(i * 17), 8'(255 - i), 8'(i << 4), 0, 0, NO_RES, NO_RES));
		// over-range width and height clamp to the limits
		steps.push_back(cfg_step(REG_FRAME_WIDTH, 13'h0FFF));
		steps.push_back(cfg_step(REG_FRAME_HEIGHT, 13'h1FFF));
		steps.push_back(pix_step(16'hAAAA, 8'h55, 8'hAA, 8'h55, 0, 0, NO_RES, NO_RES));
		steps.push_back(pix_step(16'h5555, 8'hAA, 8'h55, 8'hAA, 0, 0, NO_RES, NO_RES));
		steps.push_back(pix_step(16'hAAAA, 8'h00, 8'hFF, 8'h00, 0, 0, NO_RES, NO_RES));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table; registers change only once the block has drained
		set_idling(0);
		for (int i = 0; i < steps.size(); i++) begin
			if (steps[i].kind == STEP_CFG) begin
				if (i == 0 || steps[i-1].kind != STEP_CFG) drain();
				write_reg(steps[i].idx, steps[i].data,
					(i + 1 < steps.size()) && (steps[i+1].kind == STEP_CFG));
			end else begin
				send_pixel(steps[i].pix);
				n = predict_pixel(steps[i].pix, res);
				if (steps[i].typed) begin
					for (int k = 0; k < steps[i].n_typed; k++)
						expected_results.push_back(steps[i].want[k]);
				end else begin
					for (int k = 0; k < n; k++) expected_results.push_back(res[k]);
				end
			end
		end

		// start of the widest single-row frame, then of a one-pixel-wide frame of full height
		drain();
		write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(MAX_W), 1);
		write_reg(REG_FRAME_HEIGHT, 13'd1, 0);
		new_label_bases();
		repeat (EDGE_ITEMS) offer_pixel(rand_pixel());
		drain();
		write_reg(REG_FRAME_WIDTH, 13'd1, 1);
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(MAX_HEIGHT), 0);
		repeat (EDGE_ITEMS) offer_pixel(rand_pixel());

		// hold the receiver off while pixels keep coming, so full rises; pause midway
		drain();
		write_reg(REG_FRAME_WIDTH, 13'd6, 1);
		write_reg(REG_FRAME_HEIGHT, 13'd1, 0);
		new_label_bases();
		hold_reqs++;
		for (int i = 0; i < 36; i++) begin
			if (i == 18) wait_results();
			offer_pixel(rand_pixel());
		end

		// random frames: mostly whole frames of small size, some cut short by a restart
		while (random_items < RANDOM_ITEMS) begin
			set_idling(random_items * 3 / RANDOM_ITEMS);
			drain();
			w     = ($urandom_range(5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			h     = $urandom_range(1, 5);
			wdata = (w == 1 && $urandom_range(1)) ? '0 : CFG_DATA_BITS'(w);
			wdata[FW_BITS] = $urandom_range(1);
			hdata = (h == 1 && $urandom_range(1)) ? '0 : CFG_DATA_BITS'(h);
			if ($urandom_range(1)) begin
				write_reg(REG_FRAME_WIDTH, wdata, 1);
				write_reg(REG_FRAME_HEIGHT, hdata, 0);
			end else begin
				write_reg(REG_FRAME_HEIGHT, hdata, 1);
				write_reg(REG_FRAME_WIDTH, wdata, 0);
			end
			new_label_bases();
			frames = $urandom_range(1, 2);
			count  = frames * w * h;
			if ($urandom_range(3) == 0) count += $urandom_range(0, w * h - 1);
			if (count > 120) count = 120;
			if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
			for (int k = 0; k < count; k++) begin
				offer_pixel(rand_pixel());
				random_items++;
			end
			phases++;
		end

		drain();
		$display("run covered %0d pixels, %0d of them random over %0d frame settings",
			pixels_sent, random_items, phases);
		$display("%0d results checked, frames from 1x1 up to %0d wide and %0d tall, with stalls",
			results_seen, MAX_W, MAX_HEIGHT);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
